>>> design/wildcard_pattern_matcher_macros.svh
// Assertion macros used by the wildcard pattern matcher checker.
`ifndef WILDCARD_PATTERN_MATCHER_MACROS_SVH
`define WILDCARD_PATTERN_MATCHER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define WPM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wildcard_pattern_matcher: assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define WPM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wildcard_pattern_matcher: assertion failed");

`endif

>>> design/wpm_pkg.sv
// Types, symbol constants and byte folding for the wildcard pattern matcher.
package wpm_pkg;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_TEXT   = 2'd2,
    MODE_END    = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic       matched;
    logic       pattern_overflow;
    logic [6:0] pattern_count;
  } out_item_t;

  localparam logic [7:0] SYM_STAR = 8'h2A;
  localparam logic [7:0] SYM_ANY  = 8'h3F;
  localparam logic [7:0] UPPER_A  = 8'h41;
  localparam logic [7:0] UPPER_Z  = 8'h5A;
  localparam logic [7:0] CASE_GAP = 8'h20;

  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic fold);
    logic [7:0] res;
    res = b;
    if (fold && b >= UPPER_A && b <= UPPER_Z) begin
      res = b + CASE_GAP;
    end
    return res;
  endfunction

endpackage

>>> design/wpm_step.sv
// Per-position transition of the live set for one text byte (before star closure).
module wpm_step #(
  parameter int PATTERN_MAX = 64
) (
  input  logic [PATTERN_MAX-1:0]      live,
  input  logic [PATTERN_MAX-1:0][7:0] store,
  input  logic [PATTERN_MAX-1:0]      used,
  input  logic                        fold,
  input  logic [7:0]                  text_byte,
  output logic [PATTERN_MAX:0]        live_step
);
  import wpm_pkg::*;

  logic [7:0]             text_fold;
  logic [PATTERN_MAX-1:0] star;
  logic [PATTERN_MAX-1:0] hit;
  logic [PATTERN_MAX-1:0] stay;
  logic [PATTERN_MAX-1:0] move;

  always_comb begin
    text_fold = fold_byte(text_byte, fold);
    for (int i = 0; i < PATTERN_MAX; i++) begin
      star[i] = (store[i] == SYM_STAR);
      hit[i]  = (store[i] == SYM_ANY) || (fold_byte(store[i], fold) == text_fold);
    end
    // '*' keeps its own position live; any other match moves one position on
    stay      = live & used & star;
    move      = live & used & ~star & hit;
    live_step = {1'b0, stay} | {move, 1'b0};
  end

endmodule

>>> design/wpm_star_close.sv
// Prefix scan that spreads liveness across runs of '*' positions.
module wpm_star_close #(
  parameter int POSITIONS = 65
) (
  input  logic [POSITIONS-1:0] seed,
  input  logic [POSITIONS-2:0] star,
  output logic [POSITIONS-1:0] closed
);
  localparam int LEVELS = $clog2(POSITIONS);

  logic [POSITIONS-1:0] gen_lv  [LEVELS+1];
  logic [POSITIONS-1:0] prop_lv [LEVELS+1];

  // closed[j] = seed[j] | (star[j-1] & closed[j-1]), done in log2 levels
  always_comb begin
    gen_lv[0]  = seed;
    prop_lv[0] = {star, 1'b0};
    for (int k = 0; k < LEVELS; k++) begin
      for (int j = 0; j < POSITIONS; j++) begin
        if (j >= (1 << k)) begin
          gen_lv[k+1][j]  = gen_lv[k][j] | (prop_lv[k][j] & gen_lv[k][j-(1 << k)]);
          prop_lv[k+1][j] = prop_lv[k][j] & prop_lv[k][j-(1 << k)];
        end else begin
          gen_lv[k+1][j]  = gen_lv[k][j];
          prop_lv[k+1][j] = prop_lv[k][j];
        end
      end
    end
    closed = gen_lv[LEVELS];
  end

endmodule

>>> design/wildcard_pattern_matcher.sv
// Wildcard pattern matcher: one transaction in per cycle, one result out per
// transaction. Each accepted transaction is held in the input register,
// then the position-set update (one compare level per pattern position plus a
// star-closure prefix scan of log2(PATTERN_MAX+1) levels) writes the result
// register, which drives the out port. A new transaction is taken every cycle
// unless the input register holds one and the result register is full and
// stalled. Mode 0 clears the pattern, mode 1 appends a byte (dropped and
// flagged once PATTERN_MAX bytes are stored), mode 2 feeds a text byte, mode 3
// reports and re-arms for the next string. '?' matches one byte, '*' any run;
// fold_case lowercases A-Z on both sides; the user must write it through the
// cfg port only while idle, which the block itself does not enforce.
module wildcard_pattern_matcher #(
  parameter int PATTERN_MAX = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  wpm_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output wpm_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);
  import wpm_pkg::*;

  localparam int POSITIONS = PATTERN_MAX + 1;
  localparam int LEN_W     = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W     = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  logic                          in_vld_r;
  in_item_t                      in_item_r;
  logic                          out_vld_r;
  out_item_t                     out_item_r;
  logic                          fold_r;
  logic [LEN_W-1:0]              len_r;
  logic [LEN_W-1:0]              len_nxt;
  logic                          ovf_r;
  logic                          ovf_nxt;
  logic [POSITIONS-1:0]          live_r;
  logic [PATTERN_MAX-1:0][7:0]   store_r;

  logic                          adv;
  logic                          room;
  logic                          wr_en;
  logic [PATTERN_MAX-1:0]        used_cur;
  logic [PATTERN_MAX-1:0]        used_nxt;
  logic [PATTERN_MAX-1:0]        star_nxt;
  logic [POSITIONS-1:0]          live_step;
  logic [POSITIONS-1:0]          seed;
  logic [POSITIONS-1:0]          live_cls;
  logic                          matched;
  out_item_t                     res;

  assign adv       = in_vld_r && !(out_vld_r && out_stall);
  assign in_stall  = in_vld_r && out_vld_r && out_stall;
  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;
  assign cfg_ready = 1'b1;

  assign room  = (len_r < LEN_W'(PATTERN_MAX));
  assign wr_en = (in_item_r.mode == MODE_APPEND) && room;

  always_comb begin
    len_nxt = len_r;
    ovf_nxt = ovf_r;
    unique case (in_item_r.mode) inside
      MODE_CLEAR: begin
        len_nxt = '0;
        ovf_nxt = 1'b0;
      end
      MODE_APPEND: begin
        if (room) begin
          len_nxt = len_r + LEN_W'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
      end
      MODE_TEXT, MODE_END: begin
        len_nxt = len_r;
      end
      default: begin
        len_nxt = len_r;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      used_cur[i] = (LEN_W'(i) < len_r);
      used_nxt[i] = (LEN_W'(i) < len_nxt);
      if (wr_en && (len_r == LEN_W'(i))) begin
        star_nxt[i] = (in_item_r.byte_value == SYM_STAR);
      end else begin
        star_nxt[i] = (store_r[i] == SYM_STAR);
      end
    end
  end

  wpm_step #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_step (
    .live      (live_r[PATTERN_MAX-1:0]),
    .store     (store_r),
    .used      (used_cur),
    .fold      (fold_r),
    .text_byte (in_item_r.byte_value),
    .live_step (live_step)
  );

  // every mode but a text byte re-arms from the start position
  assign seed = (in_item_r.mode == MODE_TEXT) ? live_step : POSITIONS'(1);

  wpm_star_close #(
    .POSITIONS(POSITIONS)
  ) u_star_close (
    .seed   (seed),
    .star   (star_nxt & used_nxt),
    .closed (live_cls)
  );

  // end of text reports the set before re-arming
  assign matched = (in_item_r.mode == MODE_END) ? live_r[len_r] : live_cls[len_nxt];

  always_comb begin
    res.matched          = matched;
    res.pattern_overflow = ovf_nxt;
    res.pattern_count    = 7'(len_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      fold_r    <= 1'b0;
      len_r     <= '0;
      ovf_r     <= 1'b0;
      live_r    <= POSITIONS'(1);
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
        len_r     <= len_nxt;
        ovf_r     <= ovf_nxt;
        live_r    <= live_cls;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        fold_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_data;
    end
    if (adv) begin
      out_item_r <= res;
    end
    if (adv && wr_en) begin
      store_r[len_r[IDX_W-1:0]] <= in_item_r.byte_value;
    end
  end

endmodule

>>> design/wpm_checker.sv
// Port-level checker for the wildcard pattern matcher, bound to the top level.
`include "wildcard_pattern_matcher_macros.svh"

module wpm_checker #(
  parameter int PATTERN_MAX = 64
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input wpm_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input wpm_pkg::out_item_t out_data
);
  import wpm_pkg::*;

  // a stalled result transaction holds
  `WPM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // input side only backs up when the result register is full and stalled
  `WPM_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)

  // overflow is only reported with a full pattern
  `WPM_ASSERT_NOW(a_ovf_full, out_valid && out_data.pattern_overflow,
    out_data.pattern_count == 7'(PATTERN_MAX))

  // an accepted clear yields an empty, matching, non-overflowed result when the result register does not stall
  `WPM_ASSERT_NEXT(a_clear_result,
    (in_valid && !in_stall && in_data.mode == MODE_CLEAR) ##1 !(out_valid && out_stall),
    out_valid && out_data.matched && !out_data.pattern_overflow &&
    out_data.pattern_count == 7'd0)

endmodule

bind wildcard_pattern_matcher wpm_checker #(
  .PATTERN_MAX(PATTERN_MAX)
) u_wpm_checker (.*);
